// ----- rtl/ilh_pkg.sv -----
`default_nettype none
package ilh_pkg;

   localparam int unsigned NUM_BUCKETS_DEF = 64;

   localparam int unsigned TIME_W  = 64;
   localparam int unsigned FREQ_W  = 33;
   localparam int unsigned TICKS_W = 30;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned NS_W    = 30;   // width of the ns-per-second constant
   localparam int unsigned PROD_W  = TIME_W + NS_W;
   localparam int unsigned DIV_STEPS = 64;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [NS_W-1:0]    NS_PER_SEC     = 30'd1000000000;
   localparam logic [FREQ_W-1:0]  FREQ_RESET     = 33'd1000000000;
   localparam logic [TICKS_W-1:0] TICKS_RESET    = 30'd100000;
   localparam logic [TIME_W-1:0]  LIMIT_RESET    = 64'd0;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_FREQ   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_NS     = 2'd2;

   // opcodes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [TIME_W-1:0] entry_time;
      logic [TIME_W-1:0] now_time;
      logic [IDX_W-1:0]  bucket_select;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] latency_ns;
      logic [IDX_W-1:0]  bucket_index;
      logic [TIME_W-1:0] bucket_count;
      logic [TIME_W-1:0] sample_count;
      logic [TIME_W-1:0] max_latency_ns;
      logic              over_limit;
   } rsp_type;

   // shared divider command and status
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [FREQ_W-1:0] divisor;
      logic [FREQ_W-1:0] rem_init;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
   } div_sts_type;

endpackage
`default_nettype wire

// ----- rtl/irq_latency_histogram_core.sv -----
`default_nettype none
// Interrupt latency histogram. A record transfer carries entry and current
// timestamps; the block converts the tick delta to nanoseconds
// (delta * 1e9 / timer_freq_hz, saturated to 64 bits), bumps the matching
// bucket (delta / bucket_ticks, clamped to the last bucket), the sample
// total and the peak, and flags samples above a nonzero limit_ns. A read
// transfer returns one bucket count with the totals. One item is worked at
// a time: a record runs the 64-step shared divider twice (ns conversion,
// then bucket index); when the ns conversion saturates its divide is
// skipped. A read only reads the bucket memory and loads the result. req_ready
// returns together with rsp_valid, when the result is loaded. After reset
// the bucket memory is swept to zero, one entry per cycle, during which
// req_ready is low; csr writes are taken at any time. A finished result
// sits in an output register, so the request side is free again once the
// result is loaded.
module irq_latency_histogram_core #(
   parameter int unsigned NUM_BUCKETS = ilh_pkg::NUM_BUCKETS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_ready,
   input  ilh_pkg::req_type                 req_data,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output ilh_pkg::rsp_type                 rsp_data,
   // csr write channel
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [ilh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ilh_pkg::TIME_W-1:0]       csr_wdata
);

   localparam int unsigned AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   // wide enough for bucket_select, an address and NUM_BUCKETS itself
   localparam int unsigned SW = ((AW > ilh_pkg::IDX_W) ? AW : ilh_pkg::IDX_W) + 1;
   localparam int unsigned TW = ilh_pkg::TIME_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_NS_START,
      ST_NS_WAIT,
      ST_IDX_START,
      ST_IDX_WAIT,
      ST_MEM_RD,
      ST_BUMP,
      ST_RD_MEM,
      ST_RD_DONE,
      ST_RSP
   } state_type;

   // ---------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------
   logic [ilh_pkg::FREQ_W-1:0]  freq_ff;
   logic [ilh_pkg::TICKS_W-1:0] ticks_ff;
   logic [TW-1:0]               limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= ilh_pkg::FREQ_RESET;
         ticks_ff <= ilh_pkg::TICKS_RESET;
         limit_ff <= ilh_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ilh_pkg::CSR_TIMER_FREQ:   freq_ff  <= csr_wdata[ilh_pkg::FREQ_W-1:0];
            ilh_pkg::CSR_BUCKET_TICKS: ticks_ff <= csr_wdata[ilh_pkg::TICKS_W-1:0];
            ilh_pkg::CSR_LIMIT_NS:     limit_ff <= csr_wdata;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // zero settings behave as one
   logic [ilh_pkg::FREQ_W-1:0] freq_eff;
   logic [ilh_pkg::FREQ_W-1:0] ticks_eff;
   assign freq_eff  = (freq_ff == '0) ? ilh_pkg::FREQ_W'(1) : freq_ff;
   assign ticks_eff = (ticks_ff == '0) ? ilh_pkg::FREQ_W'(1)
                                       : ilh_pkg::FREQ_W'(ticks_ff);

   // ---------------------------------------------------------------
   // Sequencer state and datapath registers
   // ---------------------------------------------------------------
   state_type                    state_ff, state_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic                         op_ff, op_in;
   logic [TW-1:0]                delta_ff, delta_in;
   logic [61:0]                  p_lo_ff, p_lo_in;
   logic [61:0]                  p_hi_ff, p_hi_in;
   logic [ilh_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [TW-1:0]                ns_ff, ns_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [ilh_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                         in_range_ff, in_range_in;
   logic [TW-1:0]                cnt_ff, cnt_in;
   logic [TW-1:0]                total_ff, total_in;
   logic [TW-1:0]                peak_ff, peak_in;
   logic                         over_ff, over_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ilh_pkg::rsp_type             rsp_ff, rsp_in;

   // shared 32 x 30 multiplier
   logic [31:0] mul_a;
   logic [61:0] mul_p;
   assign mul_a = (state_ff == ST_MUL_HI) ? delta_ff[63:32] : delta_ff[31:0];
   assign mul_p = 62'(mul_a) * 62'(ilh_pkg::NS_PER_SEC);

   // shared divider
   ilh_pkg::div_cmd_type div_cmd;
   ilh_pkg::div_sts_type div_sts;

   ilh_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   logic ns_sat;
   assign ns_sat = {3'b000, prod_ff[ilh_pkg::PROD_W-1:TW]} >= freq_eff;

   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = delta_ff;
      div_cmd.divisor  = ticks_eff;
      div_cmd.rem_init = '0;
      if (state_ff == ST_NS_START) begin
         div_cmd.start    = !ns_sat;
         div_cmd.dividend = prod_ff[TW-1:0];
         div_cmd.divisor  = freq_eff;
         div_cmd.rem_init = {3'b000, prod_ff[ilh_pkg::PROD_W-1:TW]};
      end else if (state_ff == ST_IDX_START) begin
         div_cmd.start = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Bucket memory: one write port, one registered read port
   // ---------------------------------------------------------------
   logic [TW-1:0] mem [NUM_BUCKETS];
   logic [TW-1:0] mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [TW-1:0] mem_wdata;
   logic [TW-1:0] bumped;

   assign bumped    = mem_rdata_ff + 1'b1;
   assign mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_BUMP);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : bumped;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[addr_ff];
   end

   // read-select decode
   logic [SW-1:0] sel_wide;
   assign sel_wide = SW'(req_data.bucket_select);

   // clamp of the divider quotient to the last bucket
   logic [TW-1:0] idx_wide;
   assign idx_wide = (div_sts.quotient >= TW'(NUM_BUCKETS)) ? TW'(NUM_BUCKETS - 1)
                                                             : div_sts.quotient;

   logic req_xfer;
   logic rsp_xfer;
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      delta_in     = delta_ff;
      p_lo_in      = p_lo_ff;
      p_hi_in      = p_hi_ff;
      prod_in      = prod_ff;
      ns_in        = ns_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      in_range_in  = in_range_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      peak_in      = peak_ff;
      over_in      = over_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               op_in    = req_data.opcode;
               delta_in = req_data.now_time - req_data.entry_time;
               ns_in    = '0;
               over_in  = 1'b0;
               if (req_data.opcode == ilh_pkg::OP_READ) begin
                  addr_in     = sel_wide[AW-1:0];
                  idx_in      = req_data.bucket_select;
                  in_range_in = sel_wide < SW'(NUM_BUCKETS);
                  state_in    = ST_RD_MEM;
               end else begin
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: begin
            p_lo_in  = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            p_hi_in  = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            prod_in  = ilh_pkg::PROD_W'(p_lo_ff) + {p_hi_ff, 32'd0};
            state_in = ST_NS_START;
         end
         ST_NS_START: begin
            if (ns_sat) begin
               ns_in    = '1;
               state_in = ST_IDX_START;
            end else begin
               state_in = ST_NS_WAIT;
            end
         end
         ST_NS_WAIT: begin
            if (div_sts.done) begin
               ns_in    = div_sts.quotient;
               state_in = ST_IDX_START;
            end
         end
         ST_IDX_START: begin
            state_in = ST_IDX_WAIT;
         end
         ST_IDX_WAIT: begin
            if (div_sts.done) begin
               addr_in  = idx_wide[AW-1:0];
               idx_in   = idx_wide[ilh_pkg::IDX_W-1:0];
               state_in = ST_MEM_RD;
            end
         end
         ST_MEM_RD: begin
            state_in = ST_BUMP;
         end
         ST_BUMP: begin
            cnt_in   = bumped;
            total_in = total_ff + 1'b1;
            if (ns_ff > peak_ff) begin
               peak_in = ns_ff;
            end
            over_in  = (limit_ff != '0) && (ns_ff > limit_ff);
            state_in = ST_RSP;
         end
         ST_RD_MEM: begin
            state_in = ST_RD_DONE;
         end
         ST_RD_DONE: begin
            cnt_in   = in_range_ff ? mem_rdata_ff : '0;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            // load only when the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.latency_ns     = ns_ff;
               rsp_in.bucket_index   = idx_ff;
               rsp_in.bucket_count   = cnt_ff;
               rsp_in.sample_count   = total_ff;
               rsp_in.max_latency_ns = peak_ff;
               rsp_in.over_limit     = over_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      delta_ff    <= delta_in;
      p_lo_ff     <= p_lo_in;
      p_hi_ff     <= p_hi_in;
      prod_ff     <= prod_in;
      ns_ff       <= ns_in;
      addr_ff     <= addr_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
      cnt_ff      <= cnt_in;
      over_ff     <= over_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // one item at a time: after a request transfer the port closes
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // divider completions only land where the sequencer waits for them
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_NS_WAIT || state_ff == ST_IDX_WAIT))
      else $error("divider finished outside a wait state");

   // the sample total moves only in the bump step of a record
   a_total_on_bump: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(total_ff) |-> $past(state_ff) == ST_BUMP
         && $past(op_ff) == ilh_pkg::OP_RECORD)
      else $error("sample total changed outside a record");

   // peak never falls
   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> peak_ff >= $past(peak_ff))
      else $error("peak latency decreased");
`endif

endmodule
`default_nettype wire

// ----- rtl/ilh_divider.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. The remainder starts at
// rem_init, which must be below the divisor.
module ilh_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  ilh_pkg::div_cmd_type cmd,
   output ilh_pkg::div_sts_type sts
);

   logic [ilh_pkg::TIME_W-1:0]    work_ff, work_in;
   logic [ilh_pkg::FREQ_W-1:0]    rem_ff, rem_in;
   logic [ilh_pkg::FREQ_W-1:0]    div_ff, div_in;
   logic [ilh_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;

   logic [ilh_pkg::FREQ_W:0] rem_sh;
   logic [ilh_pkg::FREQ_W:0] rem_sub;
   logic                     ge;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[ilh_pkg::TIME_W-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};

      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         work_in = cmd.dividend;
         rem_in  = cmd.rem_init;
         div_in  = cmd.divisor;
         cnt_in  = ilh_pkg::DIV_CNT_W'(ilh_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         work_in = {work_ff[ilh_pkg::TIME_W-2:0], ge};
         rem_in  = ge ? rem_sub[ilh_pkg::FREQ_W-1:0] : rem_sh[ilh_pkg::FREQ_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == ilh_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = work_ff;

endmodule
`default_nettype wire

// ----- tb/irq_latency_histogram_core_test.sv -----
`default_nettype none
module irq_latency_histogram_core_test;
   import ilh_pkg::*;

   localparam int unsigned NUM_BINS = NUM_BUCKETS_DEF;
   // slowest legal run is roughly 1500 items, each a full record plus the widest idle gaps
   localparam int unsigned CYCLE_LIMIT = 1200000;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_ITEMS = 120;
   // csr index past the end of the register map, writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [TIME_W-1:0]    value;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   irq_latency_histogram_core #(
      .NUM_BUCKETS(NUM_BINS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block: registers and histogram state.
   logic [FREQ_W-1:0]  freq_hz   = FREQ_RESET;
   logic [TICKS_W-1:0] bin_ticks = TICKS_RESET;
   logic [TIME_W-1:0]  alarm_ns  = LIMIT_RESET;
   logic [TIME_W-1:0]  hist_bins [NUM_BINS];
   logic [TIME_W-1:0]  sample_total = '0;
   logic [TIME_W-1:0]  peak_latency = '0;

   req_type       irq_events [$];   // items waiting for the driver
   rsp_type       stats_due [$];    // predicted results, oldest first
   reg_write_type reg_writes [$];   // csr writes waiting for the csr driver
   reg_write_type next_write;

   int  req_wait = 0;
   int  rsp_wait = 0;
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;
   int  mismatches = 0;
   int  cycle_count = 0;

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // per-transfer idle draw; calm stretches run back to back
   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
      case (idx)
         CSR_TIMER_FREQ:   freq_hz = value[FREQ_W-1:0];
         CSR_BUCKET_TICKS: bin_ticks = value[TICKS_W-1:0];
         CSR_LIMIT_NS:     alarm_ns = value;
         default: ;
      endcase
   endfunction

   // Histogram update for one accepted request; pushes the result it must produce.
   function automatic void histogram_step(req_type r);
      rsp_type            e;
      logic [TIME_W-1:0]  delta;
      logic [TIME_W-1:0]  ns;
      logic [TIME_W-1:0]  slot;
      logic [TIME_W-1:0]  tk;
      logic [127:0]       div;
      logic [127:0]       quo;
      e = '0;
      if (r.opcode == OP_RECORD) begin
         delta = r.now_time - r.entry_time;   // wraps mod 2^64
         div = (freq_hz == 0) ? 128'd1 : {95'd0, freq_hz};
         tk = (bin_ticks == 0) ? 64'd1 : {34'd0, bin_ticks};
         quo = ({64'd0, delta} * {98'd0, NS_PER_SEC}) / div;
         ns = (quo[127:64] != 0) ? '1 : quo[63:0];
         if (ns > peak_latency) peak_latency = ns;
         slot = delta / tk;
         if (slot >= NUM_BINS) slot = TIME_W'(NUM_BINS - 1);
         hist_bins[slot] = hist_bins[slot] + 1;
         sample_total = sample_total + 1;
         e.latency_ns = ns;
         e.bucket_index = slot[IDX_W-1:0];
         e.bucket_count = hist_bins[slot];
         e.over_limit = (alarm_ns != 0) && (ns > alarm_ns);
      end else begin
         e.bucket_index = r.bucket_select;
         e.bucket_count = (r.bucket_select < NUM_BINS) ? hist_bins[r.bucket_select] : '0;
      end
      e.sample_count = sample_total;
      e.max_latency_ns = peak_latency;
      stats_due.push_back(e);
   endfunction

   // Request driver: presents queued items, draws an idle gap after each transfer.
   // Prediction happens at the accepting edge so it sees the state in order.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) histogram_step(req_data);
         if (req_wait > 0) begin
            req_wait = req_wait - 1;
            req_valid <= 1'b0;
         end else if (irq_events.size() != 0) begin
            req_data <= irq_events.pop_front();
            req_valid <= 1'b1;
            req_wait = draw_gap(tx_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // CSR driver: one write per transfer, shadow registers follow on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_ready) begin
         if (csr_valid) apply_register(csr_index, csr_wdata);
         if (reg_writes.size() != 0) begin
            next_write = reg_writes.pop_front();
            csr_index <= next_write.index;
            csr_wdata <= next_write.value;
            csr_valid <= 1'b1;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each transfer against the oldest prediction.
   // The stall countdown runs free, so back-pressure lands at any point
   // of the block's divide sequence, not only while a result is waiting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (stats_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: ns=%0d idx=%0d cnt=%0d",
                           rsp_data.latency_ns, rsp_data.bucket_index, rsp_data.bucket_count);
            end else if ((rsp_data.latency_ns     !== stats_due[0].latency_ns)     ||
                         (rsp_data.bucket_index   !== stats_due[0].bucket_index)   ||
                         (rsp_data.bucket_count   !== stats_due[0].bucket_count)   ||
                         (rsp_data.sample_count   !== stats_due[0].sample_count)   ||
                         (rsp_data.max_latency_ns !== stats_due[0].max_latency_ns) ||
                         (rsp_data.over_limit     !== stats_due[0].over_limit)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: exp ns=%0d idx=%0d cnt=%0d tot=%0d pk=%0d ov=%0b",
                           stats_due[0].latency_ns, stats_due[0].bucket_index,
                           stats_due[0].bucket_count, stats_due[0].sample_count,
                           stats_due[0].max_latency_ns, stats_due[0].over_limit,
                           "\n                 got ns=%0d idx=%0d cnt=%0d tot=%0d pk=%0d ov=%0b",
                           rsp_data.latency_ns, rsp_data.bucket_index, rsp_data.bucket_count,
                           rsp_data.sample_count, rsp_data.max_latency_ns, rsp_data.over_limit);
            end
            if (stats_due.size() != 0) void'(stats_due.pop_front());
            rsp_wait = draw_gap(rx_calm);
         end
         if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("irq_latency_histogram_core_test: FAIL");
      $finish;
   end

   // Idle means nothing queued, nothing presented, nothing outstanding.
   task automatic wait_idle();
      do @(negedge clock);
      while (irq_events.size() != 0 || req_valid || stats_due.size() != 0 ||
             reg_writes.size() != 0 || csr_valid);
   endtask

   task automatic queue_sample(logic [TIME_W-1:0] entry, logic [TIME_W-1:0] now);
      req_type r;
      r.opcode = OP_RECORD;
      r.entry_time = entry;
      r.now_time = now;
      r.bucket_select = IDX_W'($urandom_range(0, 63));   // ignored on records
      irq_events.push_back(r);
   endtask

   task automatic queue_delta(logic [TIME_W-1:0] delta);
      logic [TIME_W-1:0] entry;
      entry = rand64();
      queue_sample(entry, entry + delta);
   endtask

   task automatic queue_read(logic [IDX_W-1:0] sel);
      req_type r;
      r.opcode = OP_READ;
      r.entry_time = rand64();
      r.now_time = rand64();
      r.bucket_select = sel;
      irq_events.push_back(r);
   endtask

   // Write all three registers; junk above the freq and tick widths must be dropped.
   task automatic set_registers(logic [FREQ_W-1:0] f, logic [TICKS_W-1:0] t,
                                logic [TIME_W-1:0] l, bit poke_unused);
      logic [TIME_W-1:0] junk;
      wait_idle();
      junk = rand64();
      reg_writes.push_back('{CSR_TIMER_FREQ, {junk[TIME_W-1:FREQ_W], f}});
      junk = rand64();
      reg_writes.push_back('{CSR_BUCKET_TICKS, {junk[TIME_W-1:TICKS_W], t}});
      if (poke_unused) reg_writes.push_back('{CSR_UNUSED, rand64()});
      reg_writes.push_back('{CSR_LIMIT_NS, l});
      do @(negedge clock);
      while (reg_writes.size() != 0 || csr_valid);
   endtask

   // Random tick delta: mostly spread over the bins, some tiny, some huge, some placed
   // right around the alarm threshold, or around the last bin when there is no alarm.
   function automatic logic [TIME_W-1:0] pick_delta();
      logic [TIME_W-1:0] tk;
      logic [TIME_W-1:0] d;
      logic [127:0]      fe;
      logic [127:0]      scaled;
      tk = (bin_ticks == 0) ? 64'd1 : {34'd0, bin_ticks};
      fe = (freq_hz == 0) ? 128'd1 : {95'd0, freq_hz};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: d = tk * $urandom_range(0, 70) + ($urandom() % tk);
         5:             d = TIME_W'($urandom_range(0, 2000));
         6, 7:          d = rand64();
         default: begin
            if (alarm_ns == 0) begin
               d = tk * $urandom_range(60, 66);
            end else begin
               scaled = ({64'd0, alarm_ns} * fe) / {98'd0, NS_PER_SEC};
               d = (scaled[127:64] != 0) ? '1 : scaled[63:0] + $urandom_range(0, 4) - 2;
            end
         end
      endcase
      return d;
   endfunction

   initial begin
      int                 phase;
      int                 n;
      logic [FREQ_W-1:0]  f;
      logic [TICKS_W-1:0] t;
      logic [TIME_W-1:0]  l;
      logic [TIME_W-1:0]  fe;

      foreach (hist_bins[i]) hist_bins[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset register values (1 GHz, 100000 ticks/bin, no alarm)
      queue_sample('0, '0);                    // zero delta
      queue_sample('1, '0);                    // counter wrap, delta of one
      queue_sample('0, '1);                    // widest delta, top bin
      queue_delta(64'd99999);                  // last tick of bin 0
      queue_delta(64'd100000);                 // first tick of bin 1
      queue_delta(64'd6399999);                // last bin exactly
      queue_delta(64'd6400000);                // past the last bin, clamps
      queue_read(6'd0);
      queue_read(6'd63);
      queue_read(6'h2A);

      // --- directed: zero freq and zero bin width act as one, alarm at 1 ns
      set_registers('0, '0, 64'd1, 1'b1);
      queue_delta(64'd0);                      // 0 ns, not over the alarm
      queue_delta(64'd1);                      // 1e9 ns, over
      queue_delta(64'd18446744073);            // largest delta that still fits
      queue_delta(64'd18446744074);            // product overflows, saturates
      queue_delta('1);
      queue_read(6'd63);
      queue_read(6'd1);

      // --- directed: widest freq and bin width, alarm at its maximum
      set_registers('1, '1, '1, 1'b0);
      queue_delta('1);
      queue_delta(64'h8000_0000_0000_0000);
      queue_delta(64'd1);
      queue_read(6'd0);
      queue_read(6'd15);

      // --- random phases; the first six walk every register choice once
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ((phase < 6) ? phase : $urandom_range(0, 5))
            0:       f = 33'd1;
            1:       f = '1;
            2:       f = 33'd1000000000;
            3:       f = 33'd19200000;
            4:       f = {1'($urandom_range(0, 1)), $urandom()};
            default: f = '0;
         endcase
         fe = (f == 0) ? 64'd1 : {31'd0, f};
         case ((phase < 6) ? (phase + 2) % 6 : $urandom_range(0, 5))
            0:       t = 30'd1;
            1:       t = 30'd858993459;
            2:       t = '1;
            3:       t = (fe / 10000 == 0) ? 30'd1 : 30'(fe / 10000);   // driver's usual choice
            4:       t = TICKS_W'($urandom_range(1, 5000));
            default: t = '0;
         endcase
         case ((phase < 6) ? (phase + 4) % 6 : $urandom_range(0, 5))
            0:       l = '0;
            1:       l = 64'd1;
            2:       l = '1;
            3:       l = rand64();
            4:       l = TIME_W'($urandom_range(1000, 100000000));
            default: l = {32'd0, $urandom()};
         endcase
         set_registers(f, t, l, $urandom_range(0, 1));
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 3) == 0) queue_read(IDX_W'($urandom_range(0, 63)));
            else queue_delta(pick_delta());
         end
      end

      wait_idle();
      // a stray late result would show up here
      repeat (160) @(posedge clock);
      if (mismatches == 0) begin
         $display("irq_latency_histogram_core_test: PASS");
      end else begin
         $display("irq_latency_histogram_core_test: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
